FILE: src/ert_pkg.sv
// Shared types, codes and constants for the echo reply tracker.
package ert_pkg;

    localparam int unsigned SEEN_DEPTH_DEF = 1024;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO_IDENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd2;

    localparam logic [15:0] DATA_LENGTH_RST = 16'd56;
    localparam logic [16:0] ECHO_HDR_BYTES  = 17'd8;

    localparam logic       KIND_SEND = 1'b0;
    localparam logic       KIND_RECV = 1'b1;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd128;
    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd129;

    localparam logic [2:0] STS_SENT    = 3'd0;
    localparam logic [2:0] STS_SHORT   = 3'd1;
    localparam logic [2:0] STS_FOREIGN = 3'd2;
    localparam logic [2:0] STS_NEW     = 3'd3;
    localparam logic [2:0] STS_DUP     = 3'd4;
    localparam logic [2:0] STS_REQ_IGN = 3'd5;
    localparam logic [2:0] STS_OTHER   = 3'd6;

    localparam int unsigned USEC_PER_SEC   = 1000000;
    localparam int unsigned TICKS_PER_SEC  = 10000;
    localparam int unsigned USEC_PER_TICK  = 100;
    localparam int unsigned DIV100_SHIFT   = 27;
    localparam int unsigned DIV100_MUL     =
        ((32'd1 << DIV100_SHIFT) + USEC_PER_TICK - 1) / USEC_PER_TICK;

    typedef struct packed {
        logic        kind;
        logic [15:0] pkt_length;
        logic [7:0]  msg_type;
        logic [15:0] pkt_ident;
        logic [15:0] pkt_seq;
        logic [31:0] sent_sec;
        logic [19:0] sent_usec;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
    } ert_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] seq_out;
        logic [31:0] trip_time;
        logic [31:0] sent_count;
        logic [31:0] recv_count;
        logic [31:0] dup_count;
        logic [31:0] min_trip;
        logic [31:0] max_trip;
        logic [47:0] trip_sum;
        logic        last_send;
        logic        all_received;
    } ert_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MOD,
        ST_READ,
        ST_TRIP,
        ST_UPD
    } ert_state_t;

endpackage

FILE: src/ert_trip_calc.sv
// Four-stage round-trip time pipeline in 100 microsecond units, saturated to 32 bits.
module ert_trip_calc (
    input  logic        clk,
    input  logic [31:0] sent_sec,
    input  logic [19:0] sent_usec,
    input  logic [31:0] now_sec,
    input  logic [19:0] now_usec,
    output logic [31:0] trip
);
    import ert_pkg::*;

    logic signed [21:0] usec_raw;
    logic signed [21:0] usec_adj;
    logic               borrow;
    logic signed [33:0] sec_diff;

    logic signed [33:0] sec_diff_reg;
    logic               uneg_reg;
    logic        [19:0] uabs_reg;

    logic signed [47:0] sec_prod_reg;
    logic        [40:0] uq_prod_reg;
    logic               uneg2_reg;

    logic        [13:0] uq;
    logic signed [47:0] uq_s;
    logic signed [47:0] ticks_reg;
    logic        [31:0] trip_reg;

    always_comb
    begin
        usec_raw = $signed({2'b00, now_usec}) - $signed({2'b00, sent_usec});
        borrow   = usec_raw[21];
        usec_adj = borrow ? usec_raw + $signed(22'(USEC_PER_SEC)) : usec_raw;
        sec_diff = $signed({2'b00, now_sec}) - $signed({2'b00, sent_sec})
                 - $signed({33'd0, borrow});
        uq       = 14'(uq_prod_reg >> DIV100_SHIFT);
        uq_s     = $signed({34'd0, uq});
    end

    always_ff @(posedge clk)
    begin
        sec_diff_reg <= sec_diff;
        uneg_reg     <= usec_adj[21];
        uabs_reg     <= usec_adj[21] ? 20'(-usec_adj) : usec_adj[19:0];

        sec_prod_reg <= 48'(sec_diff_reg) * $signed(48'(TICKS_PER_SEC));
        uq_prod_reg  <= 41'(uabs_reg) * 41'(DIV100_MUL);
        uneg2_reg    <= uneg_reg;

        ticks_reg    <= uneg2_reg ? sec_prod_reg - uq_s : sec_prod_reg + uq_s;

        if (ticks_reg[47])
            trip_reg <= '0;
        else if (|ticks_reg[46:32])
            trip_reg <= '1;
        else
            trip_reg <= ticks_reg[31:0];
    end

    assign trip = trip_reg;

endmodule

FILE: src/echo_reply_tracker.sv
// Top level of the echo reply tracker: sequencer, seen map, statistics and result register.
//
// Request channel req_valid / req_stall / req_data carries one send or receive
// transaction; response channel rsp_valid / rsp_stall / rsp_data returns exactly
// one result per request. A transaction moves at a clock edge with valid high
// and stall low.
// Registers must be written through cfg_we / cfg_index / cfg_data while idle (not enforced).
// Each request walks a fixed sequence of states: slot division, slot remainder,
// seen map read, trip time saturation and update. The result is registered at
// the update step, which waits while a stalled result holds the output register;
// a new request is taken only once the previous one has left the update step. The
// sequence length is set by the four-stage trip time pipeline that feeds the update step.
// After reset the seen map is cleared one slot a cycle through all SEEN_DEPTH slots,
// with req_stall high throughout; register writes are taken as ever.
// A stalled result holds in the output register; the next request is still
// accepted and waits at its update step until the register frees.
module echo_reply_tracker #(
    parameter int unsigned SEEN_DEPTH = ert_pkg::SEEN_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ert_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ert_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  ert_pkg::ert_req_t                  req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output ert_pkg::ert_rsp_t                  rsp_data
);
    import ert_pkg::*;

    localparam int unsigned SLOT_W = $clog2(SEEN_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SEEN_DEPTH - 1);
    localparam longint unsigned MOD_RECIP_L =
        ((64'd1 << 32) + 64'(SEEN_DEPTH) - 64'd1) / 64'(SEEN_DEPTH);
    localparam logic [32:0] MOD_RECIP = 33'(MOD_RECIP_L);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (&v) ? v : v + 32'd1;
    endfunction

    ert_state_t state_reg, state_next;

    logic [15:0] echo_ident_reg;
    logic [15:0] data_length_reg;
    logic [31:0] count_limit_reg;

    logic [31:0] sends_reg, sends_next;
    logic [31:0] replies_reg, replies_next;
    logic [31:0] repeats_reg, repeats_next;
    logic [31:0] trip_min_reg, trip_min_next;
    logic [31:0] trip_max_reg, trip_max_next;
    logic [47:0] trip_total_reg, trip_total_next;

    logic [SLOT_W-1:0] clr_idx_reg;

    ert_req_t    item_reg;
    logic [15:0] seq_reg;
    logic [2:0]  sts_pre_reg;
    logic        reply_reg;
    logic [2:0]  sts_pre;
    logic        reply_pre;
    logic [16:0] len_min;

    logic [48:0] quot_prod;
    logic [15:0] quot_reg;
    logic [32:0] quot_mul;
    logic [15:0] rem;
    logic [SLOT_W-1:0] slot_reg;

    logic seen_mem [SEEN_DEPTH];
    logic rd_reg;
    logic mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic mem_wdata;

    logic [31:0] trip;
    logic [48:0] total_sum;
    logic        accept;
    logic        upd_fire;
    logic        rsp_valid_reg;
    ert_rsp_t    rsp_reg, rsp_next;

    ert_trip_calc u_trip (
        .clk      (clk),
        .sent_sec (item_reg.sent_sec),
        .sent_usec(item_reg.sent_usec),
        .now_sec  (item_reg.now_sec),
        .now_usec (item_reg.now_usec),
        .trip     (trip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_ident_reg  <= '0;
            data_length_reg <= DATA_LENGTH_RST;
            count_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ECHO_IDENT:  echo_ident_reg  <= cfg_data[15:0];
                REG_DATA_LENGTH: data_length_reg <= cfg_data[15:0];
                REG_COUNT_LIMIT: count_limit_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_idx_reg == SLOT_MAX) state_next = ST_IDLE;
            ST_IDLE:  if (req_valid)              state_next = ST_DIV;
            ST_DIV:   state_next = ST_MOD;
            ST_MOD:   state_next = ST_READ;
            ST_READ:  state_next = ST_TRIP;
            ST_TRIP:  state_next = ST_UPD;
            ST_UPD:   if (!rsp_valid_reg || !rsp_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        upd_fire  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
            end
            ST_IDLE: req_stall = 1'b0;
            ST_UPD:
            begin
                upd_fire  = !rsp_valid_reg || !rsp_stall;
                mem_we    = upd_fire && (!item_reg.kind || (reply_reg && !rd_reg));
                mem_wdata = item_reg.kind;
            end
            default: ;
        endcase
    end

    assign accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
        end
    end

    // Classify at acceptance.
    always_comb
    begin
        len_min   = {1'b0, data_length_reg} + ECHO_HDR_BYTES;
        reply_pre = 1'b0;
        if (req_data.kind == KIND_SEND)
            sts_pre = STS_SENT;
        else if ({1'b0, req_data.pkt_length} < len_min)
            sts_pre = STS_SHORT;
        else if (req_data.pkt_ident != echo_ident_reg)
            sts_pre = STS_FOREIGN;
        else if (req_data.msg_type == TYPE_ECHO_REPLY)
        begin
            sts_pre   = STS_NEW;
            reply_pre = 1'b1;
        end
        else if (req_data.msg_type == TYPE_ECHO_REQUEST)
            sts_pre = STS_REQ_IGN;
        else
            sts_pre = STS_OTHER;
    end

    always_comb
    begin
        quot_prod = 49'(seq_reg) * 49'(MOD_RECIP);
        quot_mul  = 33'(quot_reg) * 33'(SEEN_DEPTH);
        rem       = seq_reg - quot_mul[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= req_data;
            seq_reg     <= (req_data.kind == KIND_RECV) ? req_data.pkt_seq : sends_reg[15:0];
            sts_pre_reg <= sts_pre;
            reply_reg   <= reply_pre;
        end
        quot_reg <= quot_prod[47:32];
        slot_reg <= rem[SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seen_mem[mem_waddr] <= mem_wdata;
        rd_reg <= seen_mem[slot_reg];
    end

    always_comb
    begin
        sends_next      = sends_reg;
        replies_next    = replies_reg;
        repeats_next    = repeats_reg;
        trip_min_next   = trip_min_reg;
        trip_max_next   = trip_max_reg;
        total_sum       = {1'b0, trip_total_reg} + 49'(trip);
        trip_total_next = trip_total_reg;

        rsp_next           = '0;
        rsp_next.status    = sts_pre_reg;
        rsp_next.seq_out   = seq_reg;

        if (item_reg.kind == KIND_SEND)
            sends_next = sat_inc(sends_reg);
        else if (reply_reg)
        begin
            rsp_next.trip_time = trip;
            trip_total_next    = total_sum[48] ? '1 : total_sum[47:0];
            if (trip < trip_min_reg)
                trip_min_next = trip;
            if (trip > trip_max_reg)
                trip_max_next = trip;
            if (rd_reg)
            begin
                repeats_next    = sat_inc(repeats_reg);
                rsp_next.status = STS_DUP;
            end
            else
            begin
                replies_next    = sat_inc(replies_reg);
                rsp_next.status = STS_NEW;
            end
        end

        rsp_next.sent_count   = sends_next;
        rsp_next.recv_count   = replies_next;
        rsp_next.dup_count    = repeats_next;
        rsp_next.min_trip     = trip_min_next;
        rsp_next.max_trip     = trip_max_next;
        rsp_next.trip_sum     = trip_total_next;
        rsp_next.last_send    = (item_reg.kind == KIND_SEND) && (count_limit_reg != '0)
                              && (sends_next >= count_limit_reg);
        rsp_next.all_received = (count_limit_reg != '0) && (replies_next >= count_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sends_reg      <= '0;
            replies_reg    <= '0;
            repeats_reg    <= '0;
            trip_min_reg   <= '1;
            trip_max_reg   <= '0;
            trip_total_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else if (upd_fire)
        begin
            sends_reg      <= sends_next;
            replies_reg    <= replies_next;
            repeats_reg    <= repeats_next;
            trip_min_reg   <= trip_min_next;
            trip_max_reg   <= trip_max_next;
            trip_total_reg <= trip_total_next;
            rsp_valid_reg  <= 1'b1;
        end
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside the update step");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(accept))
        else $error("request accepted during the seen map clear");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (32'(slot_reg) < SEEN_DEPTH))
        else $error("seen map slot out of range");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ((rsp_data.recv_count != '0) || (rsp_data.dup_count != '0)))
        |-> (rsp_data.min_trip <= rsp_data.max_trip))
        else $error("min trip above max trip");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the echo reply tracker: directed and random send/receive traffic against an in-line tracker model.
module tb;
    import ert_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    ert_req_t              req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    ert_rsp_t              rsp_data;

    echo_reply_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    logic [15:0] cfg_ident = 16'd0;
    logic [15:0] cfg_dlen  = DATA_LENGTH_RST;
    logic [31:0] cfg_limit = 32'd0;

    logic [31:0] trk_sends   = '0;
    logic [31:0] trk_replies = '0;
    logic [31:0] trk_repeats = '0;
    logic [31:0] trk_min     = '1;
    logic [31:0] trk_max     = '0;
    logic [47:0] trk_total   = '0;
    bit          trk_seen [SEEN_DEPTH_DEF];

    ert_req_t    tracker_items[$];
    ert_rsp_t    tracker_reports[$];
    ert_rsp_t    due_report;
    int unsigned sends_queued   = 0;
    int unsigned send_idle_pct  = 15;
    int unsigned recv_stall_pct = 60;
    bit          hold_request   = 1'b0;
    bit          hold_used      = 1'b0;
    int unsigned hold_left      = 0;
    bit          req_taken      = 1'b0;
    int unsigned mismatches     = 0;
    int unsigned cycles         = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] inc_sat(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] trip_ticks(ert_req_t it);
        longint su;
        longint nu;
        longint ss;
        longint ns;
        longint usec;
        longint secs;
        longint ticks;
        su = it.sent_usec;
        nu = it.now_usec;
        ss = it.sent_sec;
        ns = it.now_sec;
        usec = nu - su;
        secs = ns - ss;
        if (usec < 0)
        begin
            secs = secs - 1;
            usec = usec + longint'(USEC_PER_SEC);
        end
        ticks = secs * longint'(TICKS_PER_SEC) + usec / longint'(USEC_PER_TICK);
        if (ticks < 0)
            return '0;
        if (ticks > 64'sh0000_0000_FFFF_FFFF)
            return '1;
        return ticks[31:0];
    endfunction

    function automatic ert_rsp_t track_item(ert_req_t it);
        ert_rsp_t    r;
        logic [48:0] total;
        int unsigned slot;
        r = '0;
        if (it.kind == KIND_SEND)
        begin
            r.seq_out = trk_sends[15:0];
            trk_seen[r.seq_out % SEEN_DEPTH_DEF] = 1'b0;
            trk_sends = inc_sat(trk_sends);
            r.status = STS_SENT;
            r.last_send = (cfg_limit != 32'd0) && (trk_sends >= cfg_limit);
        end
        else
        begin
            r.seq_out = it.pkt_seq;
            slot = it.pkt_seq % SEEN_DEPTH_DEF;
            if ({1'b0, it.pkt_length} < {1'b0, cfg_dlen} + ECHO_HDR_BYTES)
                r.status = STS_SHORT;
            else if (it.pkt_ident != cfg_ident)
                r.status = STS_FOREIGN;
            else if (it.msg_type == TYPE_ECHO_REPLY)
            begin
                r.trip_time = trip_ticks(it);
                total = {1'b0, trk_total} + {17'd0, r.trip_time};
                trk_total = total[48] ? '1 : total[47:0];
                if (r.trip_time < trk_min)
                    trk_min = r.trip_time;
                if (r.trip_time > trk_max)
                    trk_max = r.trip_time;
                if (trk_seen[slot])
                begin
                    trk_repeats = inc_sat(trk_repeats);
                    r.status = STS_DUP;
                end
                else
                begin
                    trk_seen[slot] = 1'b1;
                    trk_replies = inc_sat(trk_replies);
                    r.status = STS_NEW;
                end
            end
            else if (it.msg_type == TYPE_ECHO_REQUEST)
                r.status = STS_REQ_IGN;
            else
                r.status = STS_OTHER;
        end
        r.sent_count   = trk_sends;
        r.recv_count   = trk_replies;
        r.dup_count    = trk_repeats;
        r.min_trip     = trk_min;
        r.max_trip     = trk_max;
        r.trip_sum     = trk_total;
        r.all_received = (cfg_limit != 32'd0) && (trk_replies >= cfg_limit);
        return r;
    endfunction

    function automatic string rsp_text(ert_rsp_t r);
        return $sformatf("sts=%0d seq=%h trip=%h sent=%h recv=%h dup=%h min=%h max=%h sum=%h last=%b all=%b",
                         r.status, r.seq_out, r.trip_time, r.sent_count, r.recv_count,
                         r.dup_count, r.min_trip, r.max_trip, r.trip_sum, r.last_send,
                         r.all_received);
    endfunction

    task automatic log_mismatch(string what, ert_rsp_t want, ert_rsp_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s", $realtime, what);
            $display("    want %s", rsp_text(want));
            $display("    got  %s", rsp_text(got));
        end
    endtask

    function automatic ert_req_t any_item();
        ert_req_t it;
        it.kind       = 1'($urandom);
        it.pkt_length = 16'($urandom);
        it.msg_type   = 8'($urandom);
        it.pkt_ident  = 16'($urandom);
        it.pkt_seq    = 16'($urandom);
        it.sent_sec   = $urandom;
        it.sent_usec  = 20'($urandom);
        it.now_sec    = $urandom;
        it.now_usec   = 20'($urandom);
        return it;
    endfunction

    function automatic ert_req_t reply_to(logic [15:0] seq);
        ert_req_t    it;
        logic [16:0] floor_len;
        logic [16:0] len;
        int unsigned pick;
        it = any_item();
        it.kind      = KIND_RECV;
        it.msg_type  = TYPE_ECHO_REPLY;
        it.pkt_ident = cfg_ident;
        it.pkt_seq   = seq;
        floor_len = {1'b0, cfg_dlen} + ECHO_HDR_BYTES;
        pick = $urandom_range(0, 9);
        len = floor_len + 17'($urandom_range(0, 300));
        if (pick == 0)
            len = floor_len;
        else if (pick == 1)
            len = 17'h0FFFF;
        it.pkt_length = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
        it.sent_usec = 20'($urandom_range(0, 999999));
        it.now_usec  = 20'($urandom_range(0, 999999));
        case ($urandom_range(0, 19))
            0: it.now_sec = it.sent_sec - 32'd1;
            1: it.now_sec = it.sent_sec + 32'($urandom_range(429497, 2000000));
            2:
            begin
                it.now_sec   = it.sent_sec + 32'($urandom_range(0, 2));
                it.sent_usec = 20'($urandom_range(1000000, 20'hFFFFF));
                it.now_usec  = 20'($urandom);
            end
            default: it.now_sec = it.sent_sec + 32'($urandom_range(0, 3));
        endcase
        return it;
    endfunction

    task automatic push_item(ert_req_t it);
        if (it.kind == KIND_SEND)
            sends_queued++;
        tracker_items.push_back(it);
    endtask

    task automatic settle();
        while (tracker_items.size() != 0 || req_valid || tracker_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ECHO_IDENT:  cfg_ident = val[15:0];
            REG_DATA_LENGTH: cfg_dlen  = val[15:0];
            REG_COUNT_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic start_phase(logic [15:0] ident, logic [15:0] dlen, logic [31:0] limit,
                               int unsigned send_pct, int unsigned recv_pct);
        settle();
        write_reg(REG_ECHO_IDENT, {16'd0, ident});
        write_reg(REG_DATA_LENGTH, {16'd0, dlen});
        write_reg(REG_COUNT_LIMIT, limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic directed_items();
        ert_req_t it;
        ert_req_t snd;
        snd = any_item();
        snd.kind = KIND_SEND;
        push_item(snd);
        push_item(snd);
        it = reply_to(16'd0);
        it.pkt_length = 16'd64;
        it.sent_sec   = 32'd100;
        it.sent_usec  = 20'd200000;
        it.now_sec    = 32'd101;
        it.now_usec   = 20'd300000;
        push_item(it);
        push_item(it);
        it = reply_to(16'd1);
        it.sent_sec  = 32'd5;
        it.sent_usec = 20'd900000;
        it.now_sec   = 32'd7;
        it.now_usec  = 20'd100000;
        push_item(it);
        it.pkt_length = 16'd63;
        push_item(it);
        it.pkt_length = 16'd0;
        push_item(it);
        it = reply_to(16'd1);
        it.pkt_ident = ~cfg_ident;
        push_item(it);
        it = reply_to(16'd1);
        it.msg_type = TYPE_ECHO_REQUEST;
        push_item(it);
        it.msg_type = 8'h00;
        push_item(it);
        it.msg_type = 8'hFF;
        push_item(it);
        it = reply_to(16'd2);
        it.sent_sec = 32'hFFFF_FFFF;
        it.now_sec  = 32'd0;
        push_item(it);
        it = reply_to(16'd3);
        it.sent_sec  = 32'd0;
        it.sent_usec = 20'd0;
        it.now_sec   = 32'hFFFF_FFFF;
        it.now_usec  = 20'hFFFFF;
        push_item(it);
        it = reply_to(16'd4);
        it.sent_sec  = 32'd10;
        it.sent_usec = 20'hFFFFF;
        it.now_sec   = 32'd12;
        it.now_usec  = 20'd0;
        push_item(it);
        push_item(reply_to(16'(SEEN_DEPTH_DEF)));
        it = reply_to(16'hFFFF);
        it.pkt_length = 16'hFFFF;
        push_item(it);
        push_item(snd);
        push_item(reply_to(16'd2));
        it = any_item();
        it.kind = KIND_RECV;
        push_item(it);
    endtask

    task automatic random_items(int unsigned n);
        ert_req_t    it;
        int unsigned pick;
        int unsigned back;
        logic [15:0] seq;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                it = any_item();
                it.kind = KIND_SEND;
            end
            else if (pick < 80 && sends_queued != 0)
            begin
                back = $urandom_range(0, (sends_queued > 4) ? 4 : sends_queued - 1);
                seq = 16'(sends_queued - 1 - back);
                if ($urandom_range(0, 9) == 0)
                    seq = seq + 16'(SEEN_DEPTH_DEF);
                it = reply_to(seq);
            end
            else
            begin
                it = any_item();
                it.kind = KIND_RECV;
                case ($urandom_range(0, 3))
                    0: it.msg_type = TYPE_ECHO_REQUEST;
                    1: it.msg_type = TYPE_ECHO_REPLY;
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0)
                    it.pkt_ident = cfg_ident;
                if ($urandom_range(0, 1) == 0)
                    it.pkt_length = cfg_dlen + 16'd8 + 16'($urandom_range(0, 15));
            end
            push_item(it);
        end
    endtask

    // advance the request side once the last transaction has gone
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (tracker_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_data  <= tracker_items.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // hold the result side off for a long stretch once asked
    always @(negedge clk)
    begin
        if (hold_request && !hold_used)
        begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                tracker_reports.push_back(track_item(req_data));
            if (rsp_valid && !rsp_stall)
            begin
                if (tracker_reports.size() == 0)
                    log_mismatch("result with no transaction pending", '0, rsp_data);
                else
                begin
                    due_report = tracker_reports.pop_front();
                    if (rsp_data !== due_report)
                        log_mismatch("result mismatch", due_report, rsp_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        start_phase(16'hA5A5, 16'd56, 32'd2, 15, 60);
        directed_items();

        start_phase(16'($urandom), 16'($urandom_range(0, 200)), 32'd0, 15, 60);
        random_items(55);
        hold_request = 1'b1;
        settle();
        random_items(55);

        start_phase(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 15, 60);
        random_items(70);

        settle();
        start_phase(16'd0, 16'($urandom_range(0, 100)), trk_replies + 32'd12, 60, 15);
        random_items(70);

        start_phase(16'($urandom), 16'd1000, 32'd1, 60, 15);
        random_items(70);

        start_phase(16'($urandom), 16'($urandom_range(0, 1500)), 32'd0, 0, 0);
        random_items(70);

        start_phase(16'($urandom), 16'hFFFF, 32'd0, 0, 0);
        random_items(15);

        start_phase(16'($urandom), 16'hFFF7, 32'd0, 0, 0);
        random_items(25);

        settle();
        if (mismatches == 0 && tracker_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/ert_pkg.sv
src/ert_trip_calc.sv
src/echo_reply_tracker.sv
dv/tb.sv
